[hdl/recorded_op_sequence_accumulator_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the recorded operation sequence accumulator
// Shared property forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef RECORDED_OP_SEQUENCE_ACCUMULATOR_TOP_MACROS_SVH
`define RECORDED_OP_SEQUENCE_ACCUMULATOR_TOP_MACROS_SVH

// Check that a condition brings a consequence in the next cycle, outside reset
`define ROSA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition brings a consequence in the same cycle, outside reset
`define ROSA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence of reset itself, with no reset disable
`define ROSA_ASSERT_RESET(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rosa_pkg.sv]
// ---------------------------------------------------------------------------
// rosa_pkg
// Types and codes of the recorded operation sequence accumulator.
// ---------------------------------------------------------------------------
package rosa_pkg;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int DIV_STEPS = 32;

  // Request operations
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_RUN    = 1'b1;

  // Step kinds
  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DIVZERO = 2'd2;

  // One recorded step as kept in the store
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] operand;
  } step_t;

  localparam int STEP_W = $bits(step_t);

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hdl/rosa_if.sv]
// ---------------------------------------------------------------------------
// rosa_if
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface rosa_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [1:0]         op_kind;
  logic signed [31:0] operand;

  modport source (output valid, operation, op_kind, operand, input ready);
  modport sink   (input valid, operation, op_kind, operand, output ready);
endinterface

interface rosa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

[hdl/recorded_op_sequence_accumulator_top.sv]
// ---------------------------------------------------------------------------
// recorded_op_sequence_accumulator_top
// Step program store and sequenced accumulator.
// ---------------------------------------------------------------------------
// An append request stores one step (kind and operand) at the end of the
// program in a RAM; when the store is full the step is dropped and the
// result carries status FULL. A run request walks the stored steps in order,
// reading each one from the RAM and applying it to the accumulator, and
// answers with the final accumulator. Divide steps go through a radix-2
// iterative divider. A divide by zero is skipped and reported with status
// DIVZERO. Writing cfg_wdata loads the accumulator; write it only while no
// request is in flight. A new request is taken while the previous result
// still waits in the output register.
// ---------------------------------------------------------------------------
module recorded_op_sequence_accumulator_top
  import rosa_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  rosa_in_if.sink            in_req,
  rosa_out_if.source         out_rsp,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    idx_next;
  logic [DATA_W-1:0]   acc;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  logic [DATA_W-1:0]   out_value;
  logic [STATUS_W-1:0] out_status;

  logic                accept;
  logic                full;
  logic                ram_we;
  step_t               ram_wdata;
  step_t               ram_rdata;
  logic                div_start;
  div_status_t         div_stat;
  logic [DATA_W-1:0]   div_quot;
  logic                out_free;

  assign in_req.ready = (state == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign full         = (count == CNT_W'(STORE_DEPTH));
  assign idx_next     = idx + 1'b1;
  assign out_free     = !out_valid || out_rsp.ready;

  // Append writes go straight into the store at the fill count
  assign ram_we            = accept && (in_req.operation == OP_APPEND) && !full;
  assign ram_wdata.kind    = in_req.op_kind;
  assign ram_wdata.operand = in_req.operand;

  rosa_ram #(
    .WIDTH (STEP_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Start a divide only for a nonzero divisor
  assign div_start = (state == S_EXEC) && (ram_rdata.kind == KIND_DIV)
                     && (ram_rdata.operand != '0);

  rosa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (ram_rdata.operand),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Sequencer, fill count and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      acc        <= '0;
      res_status <= STATUS_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_we) begin
            acc <= cfg_wdata;
          end
          if (accept) begin
            idx <= '0;
            if (in_req.operation == OP_APPEND) begin
              res_status <= full ? STATUS_FULL : STATUS_OK;
              if (!full) begin
                count <= count + 1'b1;
              end
              state <= S_DONE;
            end else begin
              res_status <= STATUS_OK;
              state      <= (count == '0) ? S_DONE : S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          // Apply one step; divides wait for the divider
          if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= (idx_next == count) ? S_DONE : S_READ;
            idx   <= idx_next;
          end
          unique case (ram_rdata.kind)
            KIND_ADD: acc <= acc + ram_rdata.operand;
            KIND_SUB: acc <= acc - ram_rdata.operand;
            KIND_MUL: acc <= acc * ram_rdata.operand;
            KIND_DIV: begin
              if (ram_rdata.operand == '0) begin
                res_status <= STATUS_DIVZERO;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_stat.done) begin
            acc   <= div_quot;
            idx   <= idx_next;
            state <= (idx_next == count) ? S_DONE : S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_value  <= acc;
      out_status <= res_status;
    end
  end

  assign out_rsp.valid  = out_valid;
  assign out_rsp.value  = out_value;
  assign out_rsp.status = out_status;

endmodule

[hdl/rosa_ram.sv]
// ---------------------------------------------------------------------------
// rosa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module rosa_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/rosa_div.sv]
// ---------------------------------------------------------------------------
// rosa_div
// Signed 32-bit divider, truncating toward zero, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rosa_div
  import rosa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_status_t       stat,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;

  logic              neg_a;
  logic              neg_b;
  logic [DATA_W:0]   trial;
  logic [DATA_W+1:0] diff;

  assign neg_a = dividend[DATA_W-1];
  assign neg_b = divisor[DATA_W-1];

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, quo[DATA_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        cnt  <= cnt + 1'b1;
        busy <= (cnt != CNT_W'(DIV_STEPS - 1));
        done <= (cnt == CNT_W'(DIV_STEPS - 1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Datapath: load magnitudes, then one restoring step a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= neg_a ? (DATA_W'(0) - dividend) : dividend;
      dvs <= neg_b ? (DATA_W'(0) - divisor) : divisor;
      neg <= neg_a ^ neg_b;
    end else if (busy) begin
      if (!diff[DATA_W+1]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Restore the sign of the quotient
  assign quotient  = neg ? (DATA_W'(0) - quo) : quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[hdl/rosa_checker.sv]
// ---------------------------------------------------------------------------
// rosa_port_checker
// Port-level checks of the accumulator, bound to the top level.
// ---------------------------------------------------------------------------
`include "recorded_op_sequence_accumulator_top_macros.svh"

module rosa_port_checker
  import rosa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [31:0]         out_value,
  input logic [STATUS_W-1:0] out_status
);

  logic                       in_take;
  logic                       out_stall;
  logic                       status_known;
  logic [31+STATUS_W:0]       out_data;

  assign in_take      = in_valid && in_ready;
  assign out_stall    = out_valid && !out_ready;
  assign out_data     = {out_value, out_status};
  assign status_known = (out_status == STATUS_OK) || (out_status == STATUS_FULL)
                        || (out_status == STATUS_DIVZERO);

  // Reset empties the result register
  `ROSA_ASSERT_RESET(a_reset_clears, clk, rst, !out_valid, "result valid after reset")

  // A taken request keeps the block busy in the next cycle
  `ROSA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_take, !in_ready, "ready after request")

  // A stalled result holds
  `ROSA_ASSERT_NEXT(a_hold, clk, rst, out_stall, out_valid && $stable(out_data), "result moved")

  // Only defined status codes leave the block
  `ROSA_ASSERT_NOW(a_status_code, clk, rst, out_valid, status_known, "undefined status")

endmodule

bind recorded_op_sequence_accumulator_top rosa_port_checker u_rosa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_value  (out_rsp.value),
  .out_status (out_rsp.status)
);

[tb/rosa_checker.sv]
// ---------------------------------------------------------------------------
// rosa_checker
// Watches the request, result and start value ports of the recorded
// operation sequence accumulator, keeps its own copy of the step program and
// accumulator, and compares every result field by field with the oldest
// predicted answer.
// ---------------------------------------------------------------------------
module rosa_checker
  import rosa_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  rosa_in_if                 req_mon,
  rosa_out_if                rsp_mon,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_wdata,
  output int                 mismatches,
  output int                 pending,
  output int                 checked,
  output int                 full_drops,
  output int                 divzero_runs
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } answer_t;

  // Shadow of the step program and accumulator
  step_t             program_steps [STORE_DEPTH];
  int                program_len;
  logic [DATA_W-1:0] acc_model;
  answer_t           answer_q [$];

  // Signed division toward zero on raw bits; the divisor is never zero here
  function automatic logic [DATA_W-1:0] quotient_toward_zero(
    input logic [DATA_W-1:0] num,
    input logic [DATA_W-1:0] den
  );
    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;
    logic [DATA_W-1:0] quo;
    mag_n = num[DATA_W-1] ? (32'd0 - num) : num;
    mag_d = den[DATA_W-1] ? (32'd0 - den) : den;
    quo   = mag_n / mag_d;
    return (num[DATA_W-1] != den[DATA_W-1]) ? (32'd0 - quo) : quo;
  endfunction

  // Apply one request to the shadow state and return the answer it earns
  function automatic answer_t apply_request(
    input logic              op,
    input logic [KIND_W-1:0] kind,
    input logic [DATA_W-1:0] opnd
  );
    answer_t ans;
    step_t   st;
    ans.status = STATUS_OK;
    if (op == OP_APPEND) begin
      if (program_len < STORE_DEPTH) begin
        program_steps[program_len] = {kind, opnd};
        program_len++;
      end else begin
        ans.status = STATUS_FULL;
      end
    end else begin
      for (int i = 0; i < program_len; i++) begin
        st = program_steps[i];
        case (st.kind)
          KIND_ADD: acc_model = acc_model + st.operand;
          KIND_SUB: acc_model = acc_model - st.operand;
          KIND_MUL: acc_model = acc_model * st.operand;
          KIND_DIV: begin
            if (st.operand == '0) ans.status = STATUS_DIVZERO;
            else acc_model = quotient_toward_zero(acc_model, st.operand);
          end
        endcase
      end
    end
    ans.value = acc_model;
    return ans;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    mismatches++;
  endtask

  // Compare results first, then load the start value, then predict requests
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      program_len = 0;
      acc_model   = '0;
      answer_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with no request waiting", rsp_mon.value, '0);
        end else begin
          want = answer_q.pop_front();
          if (rsp_mon.value !== want.value)
            report_mismatch("value", rsp_mon.value, want.value);
          if (rsp_mon.status !== want.status)
            report_mismatch("status", 32'(rsp_mon.status), 32'(want.status));
          checked++;
        end
      end
      if (cfg_we) acc_model = cfg_wdata;
      if (req_mon.valid && req_mon.ready) begin
        want = apply_request(req_mon.operation, req_mon.op_kind, req_mon.operand);
        if (want.status == STATUS_FULL) full_drops++;
        if (want.status == STATUS_DIVZERO) divzero_runs++;
        answer_q.push_back(want);
      end
    end
    pending = answer_q.size();
  end

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Drives append and run requests into the recorded operation sequence
// accumulator with random gaps and result stalls, walks the start value
// through its extremes between phases, and gives the verdict from the
// checker's mismatch count.
// ---------------------------------------------------------------------------
module testbench
  import rosa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 50;
  localparam int IDLE_PCT    = 27;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic signed [31:0] cfg_wdata = '0;
  bit                 calm;
  int                 mismatches;
  int                 pending;
  int                 checked;
  int                 full_drops;
  int                 divzero_runs;
  int                 appends_sent;
  int                 runs_sent;
  int                 settings_used;
  int                 quiet_cycles;

  rosa_in_if  in_req();
  rosa_out_if out_rsp();

  always #5ns clk = ~clk;

  recorded_op_sequence_accumulator_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  rosa_checker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .req_mon     (in_req),
    .rsp_mon     (out_rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked),
    .full_drops  (full_drops),
    .divzero_runs(divzero_runs)
  );

  // Stall the result side at random, except in the calm phase
  always @(negedge clk) begin
    out_rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // End the run when no request and no result moves for too long
  always @(posedge clk) begin
    if (rst || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Operands: small in four of ten, extremes in one, full range in the rest
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(16) - 8;
      4: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0;
          default: return 32'h1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Hold one request until accepted; called and returning at a falling edge
  task automatic issue_request(input logic op, input logic [1:0] kind,
                               input logic [31:0] opnd);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.operation <= op;
    in_req.op_kind   <= kind;
    in_req.operand   <= opnd;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    if (op == OP_APPEND) appends_sent++;
    else runs_sent++;
  endtask

  // Drain all results, let the block settle, then load a new start value
  task automatic write_start(input logic [31:0] start);
    in_req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= start;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Appends dominate until STORE_DEPTH + 4 appends have been sent, then runs take over
  task automatic random_request();
    int append_pct;
    append_pct = (appends_sent < STORE_DEPTH + 4) ? 70 : 30;
    if ($urandom_range(99) < append_pct)
      issue_request(OP_APPEND, 2'($urandom_range(3)), pick_operand());
    else
      issue_request(OP_RUN, 2'($urandom_range(3)), $urandom());
  endtask

  initial begin
    logic [31:0] phase_starts [5];
    in_req.valid     = 1'b0;
    in_req.operation = OP_APPEND;
    in_req.op_kind   = KIND_ADD;
    in_req.operand   = '0;
    phase_starts     = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, $urandom()};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty program, most negative over minus one, extremes, zero divide
    issue_request(OP_RUN, KIND_DIV, 32'hFFFF_FFFF);
    write_start(32'h8000_0000);
    issue_request(OP_RUN, KIND_ADD, 32'h0);
    issue_request(OP_APPEND, KIND_DIV, 32'hFFFF_FFFF);
    issue_request(OP_RUN, KIND_MUL, 32'h5A5A_A5A5);
    issue_request(OP_APPEND, KIND_ADD, 32'h7FFF_FFFF);
    issue_request(OP_RUN, KIND_SUB, 32'hA5A5_5A5A);
    issue_request(OP_APPEND, KIND_SUB, 32'h8000_0000);
    issue_request(OP_APPEND, KIND_MUL, 32'hFFFF_FFFF);
    issue_request(OP_RUN, KIND_DIV, 32'h0);
    write_start(32'h7FFF_FFFF);
    issue_request(OP_RUN, KIND_ADD, 32'hFFFF_FFFF);
    issue_request(OP_APPEND, KIND_MUL, 32'd3);
    issue_request(OP_APPEND, KIND_DIV, 32'd7);
    issue_request(OP_APPEND, KIND_DIV, 32'hFFFF_FFFE);
    issue_request(OP_RUN, KIND_MUL, 32'h1);
    issue_request(OP_APPEND, KIND_SUB, 32'd1);
    issue_request(OP_RUN, KIND_SUB, 32'h8000_0000);
    issue_request(OP_APPEND, KIND_DIV, 32'h0);
    issue_request(OP_RUN, KIND_DIV, 32'h7FFF_FFFF);
    issue_request(OP_RUN, KIND_ADD, 32'h0);

    // Random phases, each under its own start value; the third runs calm
    for (int p = 0; p < 5; p++) begin
      write_start(phase_starts[p]);
      calm = (p == 2);
      repeat (PHASE_ITEMS) random_request();
    end
    calm = 1'b0;

    // Drain and let the block go quiet
    in_req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("summary: %0d requests (%0d appends, %0d runs) under %0d start values",
             appends_sent + runs_sent, appends_sent, runs_sent, settings_used);
    $display("summary: %0d results checked, %0d appends dropped on a full store, %0d runs %s",
             checked, full_drops, divzero_runs, "skipped a zero divide");
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
